@@ hw/rtl/mte_pkg.sv @@
// Package for the multi-turn encoder unwrap block: widths, codes and helpers.
`timescale 1ns / 1ps
package mte_pkg;

  localparam int TICK_BITS = 16;
  localparam int TURN_BITS = 24;
  localparam int TPR_BITS  = 17;
  localparam int OFFS_BITS = 34;
  localparam int POS_BITS  = 41;
  localparam int CNT_BITS  = 32;
  localparam int WANT_BITS = 32;
  localparam int CFG_BITS  = 17;
  localparam int IDX_BITS  = 2;
  localparam int PROD_BITS = TURN_BITS + TPR_BITS + 1;
  localparam int SUM_BITS  = POS_BITS + 3;

  localparam logic [TPR_BITS-1:0] MAX_TICKS   = TPR_BITS'(65536);
  localparam logic [TPR_BITS-1:0] RESET_TICKS = TPR_BITS'(4096);

  typedef enum logic [IDX_BITS-1:0] {
    CFG_TICKS_PER_REV = 2'd0,
    CFG_DIR_REVERSED  = 2'd1,
    CFG_START_OFFSET  = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CAL    = 1'b1
  } kind_t;

  // zero acts as one, anything past a 16-bit revolution clamps
  function automatic logic [TPR_BITS-1:0] eff_ticks(input logic [TPR_BITS-1:0] t);
    logic [TPR_BITS-1:0] r;
    r = t;
    if (t == '0) r = TPR_BITS'(1);
    else if (t > MAX_TICKS) r = MAX_TICKS;
    return r;
  endfunction

endpackage

@@ hw/rtl/multi_turn_encoder_unwrap.sv @@
// Top level of the multi-turn encoder unwrap block.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+---------------------------------------------
//  in      | input     | in_valid/ready   | kind, raw_tick, samples_seen, wanted_position
//  out     | output    | out_valid/ready  | count_out, continuous_position
//  cfg     | input     | cfg_we           | cfg_index, cfg_wdata
//
// One transaction per cycle while out_ready is high; an accepted sample passes the
// stage register (turn update ahead), then the output register (multiply-add ahead).
// Calibrate transactions update state only and give no result.
// Synchronous active-low reset empties the pipeline, clears state, sets 4096 ticks/rev.
// A stalled output holds its stage; in_ready drops only when both stages are full
// and out_ready is low.
`timescale 1ns / 1ps
module multi_turn_encoder_unwrap
  import mte_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [TICK_BITS-1:0]        in_raw_tick,
  input  logic [CNT_BITS-1:0]         in_samples_seen,
  input  logic signed [WANT_BITS-1:0] in_wanted_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [CNT_BITS-1:0]         out_count_out,
  output logic signed [POS_BITS-1:0]  out_continuous_position,
  input  logic                        cfg_we,
  input  logic [IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_BITS-1:0]         cfg_wdata
);

  // configuration
  logic [TPR_BITS-1:0]         ticks_r;
  logic                        rev_r;
  logic signed [OFFS_BITS-1:0] origin_r, origin_nxt;
  logic [TICK_BITS-1:0]        prev_raw_r, prev_raw_nxt;
  logic [TURN_BITS-1:0]        turn_r, turn_nxt;

  // stage 1
  logic                        s1_valid_r;
  logic [TICK_BITS-1:0]        s1_raw_r;
  logic [CNT_BITS-1:0]         s1_count_r;
  logic [TURN_BITS-1:0]        s1_turn_r;
  logic signed [OFFS_BITS-1:0] s1_offset_r;

  // output stage
  logic                        out_valid_r;
  logic [CNT_BITS-1:0]         out_count_r;
  logic signed [POS_BITS-1:0]  out_pos_r;

  logic                        out_adv, in_acc, is_cal;
  logic [TPR_BITS-1:0]         ticks_eff;
  logic [TICK_BITS-1:0]        diff_abs;
  logic                        wrap;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [SUM_BITS-1:0]  pos_full;

  assign out_adv   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || out_adv;
  assign in_acc    = in_valid && in_ready;
  assign is_cal    = (kind_t'(in_kind) == KIND_CAL);
  assign ticks_eff = eff_ticks(ticks_r);

  // wrap detection and turn counter update
  always_comb begin
    diff_abs = (in_raw_tick >= prev_raw_r) ? (in_raw_tick - prev_raw_r)
                                           : (prev_raw_r - in_raw_tick);
    wrap = (in_samples_seen > CNT_BITS'(1)) &&
           ({1'b0, diff_abs} >= (ticks_eff >> 1));
    turn_nxt      = turn_r;
    prev_raw_nxt  = prev_raw_r;
    origin_nxt    = origin_r;
    if (in_acc) begin
      if (is_cal) begin
        turn_nxt = '0;
        origin_nxt = OFFS_BITS'($signed({1'b0, in_raw_tick})) -
                     OFFS_BITS'(in_wanted_position);
      end else begin
        prev_raw_nxt = in_raw_tick;
        if (wrap) begin
          turn_nxt = (in_raw_tick < prev_raw_r) ? turn_r + TURN_BITS'(1)
                                                : turn_r - TURN_BITS'(1);
        end
      end
    end
    if (cfg_we && cfg_idx_t'(cfg_index) == CFG_START_OFFSET) begin
      origin_nxt = OFFS_BITS'($signed(cfg_wdata));
    end
  end

  // position = raw + turns * ticks - offset, negated when reversed
  always_comb begin
    prod     = $signed(s1_turn_r) * $signed({1'b0, ticks_eff});
    sum      = SUM_BITS'(prod) + SUM_BITS'($signed({1'b0, s1_raw_r})) -
               SUM_BITS'(s1_offset_r);
    pos_full = rev_r ? -sum : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r       <= RESET_TICKS;
      rev_r         <= 1'b0;
      origin_r      <= '0;
      prev_raw_r    <= '0;
      turn_r        <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      origin_r      <= origin_nxt;
      prev_raw_r    <= prev_raw_nxt;
      turn_r        <= turn_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TICKS_PER_REV: ticks_r <= cfg_wdata[TPR_BITS-1:0];
          CFG_DIR_REVERSED:  rev_r   <= cfg_wdata[0];
          CFG_START_OFFSET:  ;
          CFG_UNUSED:        ;
        endcase
      end
      if (in_ready) s1_valid_r <= in_acc && !is_cal;
      if (out_adv)  out_valid_r <= s1_valid_r;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc && !is_cal) begin
      s1_raw_r    <= in_raw_tick;
      s1_count_r  <= in_samples_seen;
      s1_turn_r   <= turn_nxt;
      s1_offset_r <= origin_r;
    end
    if (out_adv && s1_valid_r) begin
      out_count_r <= s1_count_r;
      out_pos_r   <= pos_full[POS_BITS-1:0];
    end
  end

  assign out_valid               = out_valid_r;
  assign out_count_out           = out_count_r;
  assign out_continuous_position = out_pos_r;

endmodule

@@ hw/rtl/mte_checker.sv @@
// Port-level assertion checker for the encoder unwrap block, with its bind.
`timescale 1ns / 1ps
module mte_sva
  import mte_pkg::*;
(
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_kind,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [CNT_BITS-1:0]         out_count_out,
  input logic signed [POS_BITS-1:0]  out_continuous_position
);

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with output stage empty");

  // an accepted sample keeps the output stage occupied once past the stage register
  a_sample_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == KIND_SAMPLE) |=> ##1 out_valid)
    else $error("sample transaction did not reach the output");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_count_out) && $stable(out_continuous_position)))
    else $error("stalled result changed");

endmodule

bind multi_turn_encoder_unwrap mte_sva u_mte_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_valid),
  .in_ready                (in_ready),
  .in_kind                 (in_kind),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_count_out           (out_count_out),
  .out_continuous_position (out_continuous_position)
);
